// ----- hdl/uampq_pkg.sv -----
// Package for the unsorted-array max-priority queue.
// Holds the sizes, command and status codes and the sequencer state type.
// Depends on nothing; used by the top level and the testbench, not by uampq_ram.
package uampq_pkg;

    localparam int CAPACITY = 16;
    localparam int POS_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 5;
    localparam int VALUE_W  = 31;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;
    localparam int M_PAD_W  = M_DATA_W - (VALUE_W + STATUS_W + CNT_W);

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_PEEK   = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } t_state;

endpackage

// ----- hdl/uampq_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the entry store of the priority queue; depends on nothing.
module uampq_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/unsorted_array_max_priority_queue_top.sv -----
// Top level of the unsorted-array max-priority queue.
// Depends on uampq_pkg and on uampq_ram for the entry store.
//
// Each input transaction carries a command (insert, remove maximum, peek maximum,
// or no operation) and a value; each one yields exactly one output transaction
// with a result value (the maximum for a remove or peek on a non-empty queue,
// else zero), a status and the count after the step. The result is registered
// at the cycle the input transaction is taken. A remove that leaves entries
// delivers its result at once, then shifts the later entries down and rescans
// for the new maximum through the entry RAM, one entry per cycle over its single
// read port; the block takes no input until the rescan is done. A result that
// waits on the output also holds off the next input transaction.
module unsorted_array_max_priority_queue_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // Fields from bit 0: command[1:0], value[32:2], zero padding.
    input  logic [uampq_pkg::S_DATA_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // Fields from bit 0: result_value[30:0], status[32:31], count[37:33], padding.
    output logic [uampq_pkg::M_DATA_W-1:0] m_axis_tdata
);

    import uampq_pkg::*;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [POS_W-1:0]     r_max_pos, n_max_pos;
    logic [VALUE_W-1:0]   r_max_val, n_max_val;
    logic [CNT_W-1:0]     r_idx, n_idx;
    logic                 r_pend, n_pend;
    logic [POS_W-1:0]     r_pend_idx, n_pend_idx;
    logic [VALUE_W-1:0]   r_best, n_best;
    logic [POS_W-1:0]     r_best_pos, n_best_pos;
    logic                 r_out_valid, n_out_valid;
    logic [M_DATA_W-1:0]  r_out_data, n_out_data;

    logic                 in_acc;
    t_cmd                 cmd;
    logic [VALUE_W-1:0]   in_value;
    logic                 is_full;
    logic                 is_empty;
    logic                 scan_last;
    logic [CNT_W-1:0]     idx_inc;
    logic [CNT_W-1:0]     count_dec;
    logic [VALUE_W-1:0]   best_sel;
    logic [POS_W-1:0]     best_pos_sel;
    t_status              out_status;
    logic [VALUE_W-1:0]   out_value;

    logic                 wr_en;
    logic [POS_W-1:0]     wr_addr;
    logic [VALUE_W-1:0]   wr_data;
    logic [POS_W-1:0]     rd_addr;
    logic [VALUE_W-1:0]   rd_data;

    uampq_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(CAPACITY)
    ) u_entries (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cmd           = t_cmd'(s_axis_tdata[CMD_W-1:0]);
    assign in_value      = s_axis_tdata[CMD_W +: VALUE_W];
    assign is_full       = (r_count == CNT_W'(CAPACITY));
    assign is_empty      = (r_count == '0);
    assign idx_inc       = r_idx + CNT_W'(1);
    assign count_dec     = r_count - CNT_W'(1);
    assign scan_last     = r_pend && ({1'b0, r_pend_idx} == count_dec);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && cmd == CMD_REMOVE && r_count > CNT_W'(1)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (r_pend && rd_data >= r_best) begin
            best_sel     = rd_data;
            best_pos_sel = r_pend_idx;
        end else begin
            best_sel     = r_best;
            best_pos_sel = r_best_pos;
        end
    end

    always_comb begin
        n_count     = r_count;
        n_max_pos   = r_max_pos;
        n_max_val   = r_max_val;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_pend_idx  = r_pend_idx;
        n_best      = r_best;
        n_best_pos  = r_best_pos;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        out_status  = ST_OK;
        out_value   = '0;
        wr_en       = 1'b0;
        wr_addr     = r_count[POS_W-1:0];
        wr_data     = in_value;
        rd_addr     = '0;

        if (in_acc) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (cmd)
                        CMD_INSERT: begin
                            if (is_full) begin
                                out_status = ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = r_count + CNT_W'(1);
                                if (is_empty || in_value > r_max_val) begin
                                    n_max_pos = r_count[POS_W-1:0];
                                    n_max_val = in_value;
                                end
                            end
                        end
                        CMD_REMOVE: begin
                            if (is_empty) begin
                                out_status = ST_EMPTY;
                            end else begin
                                out_value  = r_max_val;
                                n_count    = count_dec;
                                n_idx      = '0;
                                n_best     = '0;
                                n_best_pos = '0;
                                if (r_count == CNT_W'(1)) begin
                                    n_max_pos = '0;
                                end
                            end
                        end
                        CMD_PEEK: begin
                            if (is_empty) begin
                                out_status = ST_EMPTY;
                            end else begin
                                out_value = r_max_val;
                            end
                        end
                        CMD_NOP: begin
                        end
                        default: begin
                        end
                    endcase
                    n_out_data = {{M_PAD_W{1'b0}}, n_count, out_status, out_value};
                end
            end
            S_SCAN: begin
                if (r_idx < r_count) begin
                    rd_addr    = (r_idx < {1'b0, r_max_pos}) ? r_idx[POS_W-1:0]
                                                              : idx_inc[POS_W-1:0];
                    n_pend     = 1'b1;
                    n_pend_idx = r_idx[POS_W-1:0];
                    n_idx      = idx_inc;
                end
                if (r_pend) begin
                    wr_en      = (r_pend_idx >= r_max_pos);
                    wr_addr    = r_pend_idx;
                    wr_data    = rd_data;
                    n_best     = best_sel;
                    n_best_pos = best_pos_sel;
                end
                if (scan_last) begin
                    n_max_pos = best_pos_sel;
                    n_max_val = best_sel;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_max_pos   <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_max_pos   <= n_max_pos;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_max_val  <= n_max_val;
        r_pend_idx <= n_pend_idx;
        r_best     <= n_best;
        r_best_pos <= n_best_pos;
        r_out_data <= n_out_data;
    end

endmodule

// ----- tb/unsorted_array_max_priority_queue_top_tb.sv -----
// Testbench for the unsorted-array max-priority queue top level.
// Drives command streams, predicts each result in a scoreboard class, and compares.
// Depends on uampq_pkg and on unsorted_array_max_priority_queue_top.
`timescale 1ns / 100ps

module unsorted_array_max_priority_queue_top_tb;

    import uampq_pkg::*;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        t_status            status;
        logic [CNT_W-1:0]   count;
    } t_queue_result;

    class t_maxq_scoreboard;
        logic [VALUE_W-1:0] entries [CAPACITY];
        int unsigned        stored;
        int unsigned        max_pos;
        t_queue_result      expected_results [$];
        int                 errors;

        function new();
            stored  = 0;
            max_pos = 0;
            errors  = 0;
        endfunction

        function void rescan();
            logic [VALUE_W-1:0] best;
            best    = '0;
            max_pos = 0;
            for (int i = 0; i < stored; i++) begin
                if (entries[i] >= best) begin
                    best    = entries[i];
                    max_pos = i;
                end
            end
        endfunction

        function void note_command(t_cmd cmd, logic [VALUE_W-1:0] v);
            t_queue_result res;
            res.value  = '0;
            res.status = ST_OK;
            if (cmd == CMD_INSERT) begin
                if (stored >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    entries[stored] = v;
                    if (stored == 0 || v > entries[max_pos]) max_pos = stored;
                    stored++;
                end
            end else if (cmd == CMD_REMOVE || cmd == CMD_PEEK) begin
                if (stored == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.value = entries[max_pos];
                    if (cmd == CMD_REMOVE) begin
                        for (int i = max_pos; i + 1 < stored; i++) entries[i] = entries[i + 1];
                        stored--;
                        rescan();
                    end
                end
            end
            res.count = stored[CNT_W-1:0];
            expected_results.push_back(res);
        endfunction

        task report_mismatch(string what, longint unsigned got, longint unsigned want);
            $display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
            errors++;
        endtask

        task check_result(logic [M_DATA_W-1:0] data);
            t_queue_result want;
            logic [VALUE_W-1:0] got_value;
            logic [STATUS_W-1:0] got_status;
            logic [CNT_W-1:0] got_count;
            got_value  = data[VALUE_W-1:0];
            got_status = data[VALUE_W+STATUS_W-1:VALUE_W];
            got_count  = data[VALUE_W+STATUS_W+CNT_W-1:VALUE_W+STATUS_W];
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, value", got_value, 0);
                return;
            end
            want = expected_results.pop_front();
            if (got_value !== want.value) report_mismatch("value", got_value, want.value);
            if (got_status !== want.status) report_mismatch("status", got_status, want.status);
            if (got_count !== want.count) report_mismatch("count", got_count, want.count);
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    // Fields from bit 0: command[1:0], value[32:2], zero padding.
    logic [S_DATA_W-1:0] s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    // Fields from bit 0: result_value[30:0], status[32:31], count[37:33], padding.
    logic [M_DATA_W-1:0] m_axis_tdata;

    t_maxq_scoreboard sb;
    int               send_idle_pct;
    int               recv_stall_pct;

    unsorted_array_max_priority_queue_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic logic [VALUE_W-1:0] random_value();
        return VALUE_W'($urandom());
    endfunction

    function automatic logic [VALUE_W-1:0] random_priority();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) return VALUE_W'($urandom_range(0, 7));
        if (pick < 45) return '0;
        if (pick < 50) return '1;
        return random_value();
    endfunction

    task automatic send_item(t_cmd cmd, logic [VALUE_W-1:0] v);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct && gap < 60) gap++;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {{(S_DATA_W - VALUE_W - CMD_W){1'b0}}, v, cmd};
        forever begin
            @(posedge i_clk);
            if (s_axis_tready) break;
            @(negedge i_clk);
        end
        sb.note_command(cmd, v);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_random_phase(int mixed_items);
        int insert_pct;
        int unsigned r;
        insert_pct = 50;
        repeat (CAPACITY + 2) send_item(CMD_INSERT, random_priority());
        for (int n = 0; n < mixed_items; n++) begin
            if (n % 20 == 0) begin
                r = $urandom_range(0, 2);
                insert_pct = (r == 0) ? 30 : (r == 1) ? 50 : 75;
            end
            if ($urandom_range(0, 99) < insert_pct) begin
                send_item(CMD_INSERT, random_priority());
            end else begin
                r = $urandom_range(0, 9);
                if (r < 6) send_item(CMD_REMOVE, random_value());
                else if (r < 9) send_item(CMD_PEEK, random_value());
                else send_item(CMD_NOP, random_value());
            end
        end
        repeat (CAPACITY + 2) send_item(CMD_REMOVE, random_value());
    endtask

    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            m_axis_tready = ($urandom_range(0, 99) >= recv_stall_pct);
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
        end
    end

    initial begin
        #1000000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        sb             = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_item(CMD_PEEK, '1);
        send_item(CMD_REMOVE, '1);
        send_item(CMD_NOP, '1);
        send_item(CMD_INSERT, '0);
        send_item(CMD_INSERT, 31'd9);
        send_item(CMD_INSERT, 31'd9);
        send_item(CMD_INSERT, 31'd3);
        send_item(CMD_PEEK, '0);
        send_item(CMD_REMOVE, '0);
        send_item(CMD_REMOVE, '0);
        send_item(CMD_INSERT, '1);
        send_item(CMD_INSERT, '1);
        send_item(CMD_INSERT, 31'h2AAA_AAAA);
        send_item(CMD_PEEK, 31'h5555_5555);
        send_item(CMD_REMOVE, '0);
        send_item(CMD_NOP, '0);
        send_item(CMD_REMOVE, '0);
        send_item(CMD_REMOVE, '0);
        send_item(CMD_REMOVE, '0);
        send_item(CMD_REMOVE, '0);
        send_item(CMD_PEEK, '0);
        send_item(CMD_INSERT, 31'd1);
        send_item(CMD_REMOVE, '0);
        wait_drained();

        run_random_phase(120);
        wait_drained();
        send_idle_pct = 75;
        run_random_phase(120);
        wait_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 75;
        run_random_phase(120);
        wait_drained();
        send_idle_pct  = 11;
        recv_stall_pct = 11;
        run_random_phase(120);

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
